@@ src/kvp_pkg.sv @@
// Package for the keypoint vote peak finder: defaults, register indexes,
// frame geometry struct and saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kvp_pkg;

    localparam int MAX_WIDTH_DEF       = 256;
    localparam int MAX_HEIGHT_DEF      = 256;
    localparam int MAX_PEAKS_DEF       = 64;
    localparam int MAX_VOTE_WINDOW_DEF = 7;
    localparam int MAX_PEAK_WINDOW_DEF = 15;

    // Clamped frame sizes fit the largest MAX_WIDTH / MAX_HEIGHT (4096).
    localparam int DIM_W = 13;

    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_VOTE_SCALE     = 3'd2;
    localparam logic [2:0] REG_VOTE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_PEAK_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_VOTE_WINDOW    = 3'd5;
    localparam logic [2:0] REG_PEAK_WINDOW    = 3'd6;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [3:0]       half_vote;
        logic [4:0]       half_peak;
    } kvp_geom_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

@@ src/kvp_vote_accum.sv @@
// Vote accumulation: pixel counters, vote memory read-modify-write, box-sum
// pass into the filtered map and clearing sweep. Depends on kvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvp_vote_accum #(
    parameter int MAX_WIDTH       = kvp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = kvp_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_VOTE_WINDOW = kvp_pkg::MAX_VOTE_WINDOW_DEF,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire [15:0]              confidence,
    input  wire signed [15:0]       shift_x,
    input  wire signed [15:0]       shift_y,
    input  wire                     end_of_frame,
    input  kvp_pkg::kvp_geom_t      geom,
    input  wire [11:0]              vote_scale,
    input  wire [15:0]              vote_threshold,
    input  wire                     peak_busy,
    output logic                    filt_we,
    output logic [AW-1:0]           filt_addr,
    output logic [31:0]             filt_data,
    output logic                    scan_start,
    output logic                    accum_busy
);
    import kvp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CDW   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int CW    = CDW + 6;
    localparam int SW    = (CDW > 9 ? CDW : 9) + 20;
    localparam int QW    = SW - 18;
    localparam int ACCW  = 33 + $clog2(MAX_VOTE_WINDOW * MAX_VOTE_WINDOW);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_WRITE, S_BOX_RD, S_BOX_END
    } state_t;

    state_t                 state_reg, state_next;
    logic [15:0]            conf_reg, conf_next;
    logic                   eof_reg, eof_next;
    logic signed [27:0]     prodx_reg, prodx_next, prody_reg, prody_next;
    logic [XW-1:0]          col_reg, col_next;
    logic [YW-1:0]          row_reg, row_next;
    logic [AW-1:0]          vaddr_reg, vaddr_next;
    logic                   hit_reg, hit_next;
    logic [XW-1:0]          bx_reg, bx_next;
    logic [YW-1:0]          by_reg, by_next;
    logic signed [CW-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [ACCW-1:0]        acc_reg, acc_next;
    logic                   tapv_reg, tapv_next;
    logic [AW-1:0]          clr_reg, clr_next;

    logic [31:0]            mem [DEPTH];
    logic [31:0]            rd_data_reg;
    logic [AW-1:0]          mem_raddr, mem_waddr;
    logic [31:0]            mem_wdata;
    logic                   mem_we;

    logic signed [SW-1:0]   sx, sy;
    logic [QW-1:0]          qx, qy;
    logic                   okx, oky;
    logic [XW-1:0]          vx;
    logic [YW-1:0]          vy;
    logic signed [CW-1:0]   hv, tx, ty;
    logic                   inb;
    logic [ACCW-1:0]        acc_sum;
    logic                   last_pos;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        sx = (SW'(signed'({1'b0, col_reg})) <<< 18) + SW'(prodx_reg);
        sy = (SW'(signed'({1'b0, row_reg})) <<< 18) + SW'(prody_reg);
        qx = sx[SW-1:18];
        qy = sy[SW-1:18];
        if (sx[SW-1])
        begin
            okx = (&qx) && (sx[17:0] != 18'd0);
            vx  = '0;
        end
        else
        begin
            okx = 32'(qx) < 32'(geom.width);
            vx  = qx[XW-1:0];
        end
        if (sy[SW-1])
        begin
            oky = (&qy) && (sy[17:0] != 18'd0);
            vy  = '0;
        end
        else
        begin
            oky = 32'(qy) < 32'(geom.height);
            vy  = qy[YW-1:0];
        end

        hv  = signed'(CW'(geom.half_vote));
        tx  = signed'(CW'(bx_reg)) + dx_reg;
        ty  = signed'(CW'(by_reg)) + dy_reg;
        inb = (tx >= 0) && (tx < signed'(CW'(geom.width)))
            && (ty >= 0) && (ty < signed'(CW'(geom.height)));
        acc_sum  = acc_reg + (tapv_reg ? ACCW'(rd_data_reg) : '0);
        last_pos = (DIM_W'(bx_reg) + 1'b1 >= geom.width)
                && (DIM_W'(by_reg) + 1'b1 >= geom.height);
    end

    always_comb
    begin
        state_next = state_reg;
        conf_next  = conf_reg;
        eof_next   = eof_reg;
        prodx_next = prodx_reg;
        prody_next = prody_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        vaddr_next = vaddr_reg;
        hit_next   = hit_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        acc_next   = acc_reg;
        tapv_next  = 1'b0;
        clr_next   = clr_reg;
        mem_raddr  = AW'(ty) * AW'(MAX_WIDTH) + AW'(tx);
        mem_waddr  = clr_reg;
        mem_wdata  = '0;
        mem_we     = 1'b0;
        filt_we    = 1'b0;
        filt_addr  = AW'(by_reg) * AW'(MAX_WIDTH) + AW'(bx_reg);
        filt_data  = (|acc_sum[ACCW-1:32]) ? 32'hFFFF_FFFF : acc_sum[31:0];
        scan_start = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !peak_busy)
                begin
                    conf_next  = confidence;
                    eof_next   = end_of_frame;
                    prodx_next = signed'({1'b0, vote_scale}) * shift_x;
                    prody_next = signed'({1'b0, vote_scale}) * shift_y;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                // issue the vote read and step the raster counters
                mem_raddr  = AW'(vy) * AW'(MAX_WIDTH) + AW'(vx);
                vaddr_next = mem_raddr;
                hit_next   = (conf_reg > vote_threshold) && okx && oky;
                if (eof_reg)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (DIM_W'(col_reg) + 1'b1 >= geom.width)
                begin
                    col_next = '0;
                    row_next = (DIM_W'(row_reg) + 1'b1 >= geom.height) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we    = hit_reg;
                mem_waddr = vaddr_reg;
                mem_wdata = sat_add32(rd_data_reg, conf_reg);
                if (eof_reg)
                begin
                    bx_next    = '0;
                    by_next    = '0;
                    dx_next    = -hv;
                    dy_next    = -hv;
                    acc_next   = '0;
                    state_next = S_BOX_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BOX_RD:
            begin
                tapv_next = inb;
                acc_next  = acc_sum;
                if (dx_reg == hv)
                begin
                    dx_next = -hv;
                    if (dy_reg == hv)
                    begin
                        state_next = S_BOX_END;
                    end
                    else
                    begin
                        dy_next = dy_reg + 1'b1;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            S_BOX_END:
            begin
                filt_we  = 1'b1;
                acc_next = '0;
                dx_next  = -hv;
                dy_next  = -hv;
                if (last_pos)
                begin
                    scan_start = 1'b1;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                else
                begin
                    if (DIM_W'(bx_reg) + 1'b1 >= geom.width)
                    begin
                        bx_next = '0;
                        by_next = by_reg + 1'b1;
                    end
                    else
                    begin
                        bx_next = bx_reg + 1'b1;
                    end
                    state_next = S_BOX_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            hit_reg   <= 1'b0;
            eof_reg   <= 1'b0;
            tapv_reg  <= 1'b0;
            bx_reg    <= '0;
            by_reg    <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            hit_reg   <= hit_next;
            eof_reg   <= eof_next;
            tapv_reg  <= tapv_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conf_reg  <= conf_next;
        prodx_reg <= prodx_next;
        prody_reg <= prody_next;
        vaddr_reg <= vaddr_next;
        acc_reg   <= acc_next;
    end

    assign in_stall   = (state_reg != S_IDLE) || peak_busy;
    assign accum_busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ src/kvp_peak_scan.sv @@
// Peak scan: filtered map memory, local-maximum test, peak list memory and
// result output register. Depends on kvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvp_peak_scan #(
    parameter int MAX_WIDTH  = kvp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = kvp_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_PEAKS  = kvp_pkg::MAX_PEAKS_DEF,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  kvp_pkg::kvp_geom_t  geom,
    input  wire [31:0]          peak_threshold,
    input  wire                 filt_we,
    input  wire [AW-1:0]        filt_addr,
    input  wire [31:0]          filt_data,
    input  wire                 scan_start,
    output logic                peak_busy,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [7:0]          stem_x,
    output logic [7:0]          stem_y,
    output logic                peak_found,
    output logic                peaks_dropped,
    output logic                last_result
);
    import kvp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CDW   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int CW    = CDW + 6;
    localparam int CNW   = $clog2(MAX_PEAKS + 1);
    localparam int IW    = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

    typedef enum logic [2:0] {
        P_IDLE, P_CTR, P_CHK, P_TAP, P_TAP_END, P_EMIT_RD, P_EMIT_LD, P_EMIT_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [XW-1:0]          px_reg, px_next;
    logic [YW-1:0]          py_reg, py_next;
    logic signed [CW-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]            v_reg, v_next, mx_reg, mx_next;
    logic                   tapv_reg, tapv_next;
    logic [CNW-1:0]         cnt_reg, cnt_next, k_reg, k_next;
    logic                   drop_reg, drop_next;
    logic                   ov_reg, ov_next;
    logic [7:0]             ox_reg, ox_next, oy_reg, oy_next;
    logic                   of_reg, of_next, od_reg, od_next, ol_reg, ol_next;

    logic [31:0]            fmem [DEPTH];
    logic [31:0]            rd_data_reg;
    logic [AW-1:0]          raddr;

    logic [XW+YW-1:0]       list [MAX_PEAKS];
    logic [XW+YW-1:0]       list_rd_reg;
    logic                   list_we;

    logic signed [CW-1:0]   hp, tx, ty;
    logic                   inb, last_pos;
    logic [31:0]            mx_fin;

    always_ff @(posedge clk)
    begin
        if (filt_we)
        begin
            fmem[filt_addr] <= filt_data;
        end
        rd_data_reg <= fmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list[cnt_reg[IW-1:0]] <= {py_reg, px_reg};
        end
        list_rd_reg <= list[k_reg[IW-1:0]];
    end

    always_comb
    begin
        hp  = signed'(CW'(geom.half_peak));
        tx  = signed'(CW'(px_reg)) + dx_reg;
        ty  = signed'(CW'(py_reg)) + dy_reg;
        inb = (tx >= 0) && (tx < signed'(CW'(geom.width)))
            && (ty >= 0) && (ty < signed'(CW'(geom.height)));
        last_pos = (DIM_W'(px_reg) + 1'b1 >= geom.width)
                && (DIM_W'(py_reg) + 1'b1 >= geom.height);
        mx_fin = (tapv_reg && rd_data_reg > mx_reg) ? rd_data_reg : mx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        v_next     = v_reg;
        mx_next    = mx_reg;
        tapv_next  = 1'b0;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        drop_next  = drop_reg;
        ov_next    = ov_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        of_next    = of_reg;
        od_next    = od_reg;
        ol_next    = ol_reg;
        list_we    = 1'b0;
        raddr      = AW'(py_reg) * AW'(MAX_WIDTH) + AW'(px_reg);

        unique case (state_reg)
            P_IDLE:
            begin
                if (scan_start)
                begin
                    px_next    = '0;
                    py_next    = '0;
                    cnt_next   = '0;
                    drop_next  = 1'b0;
                    state_next = P_CTR;
                end
            end
            P_CTR:
            begin
                state_next = P_CHK;
            end
            P_CHK, P_TAP_END:
            begin
                // decide on the center value, or close out the window maximum
                if (state_reg == P_CHK && rd_data_reg > peak_threshold)
                begin
                    v_next     = rd_data_reg;
                    mx_next    = '0;
                    dx_next    = -hp;
                    dy_next    = -hp;
                    state_next = P_TAP;
                end
                else
                begin
                    if (state_reg == P_TAP_END && mx_fin == v_reg)
                    begin
                        if (cnt_reg < CNW'(MAX_PEAKS))
                        begin
                            list_we  = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    if (last_pos)
                    begin
                        k_next     = '0;
                        state_next = P_EMIT_RD;
                    end
                    else
                    begin
                        if (DIM_W'(px_reg) + 1'b1 >= geom.width)
                        begin
                            px_next = '0;
                            py_next = py_reg + 1'b1;
                        end
                        else
                        begin
                            px_next = px_reg + 1'b1;
                        end
                        state_next = P_CTR;
                    end
                end
            end
            P_TAP:
            begin
                raddr     = AW'(ty) * AW'(MAX_WIDTH) + AW'(tx);
                tapv_next = inb;
                mx_next   = mx_fin;
                if (dx_reg == hp)
                begin
                    dx_next = -hp;
                    if (dy_reg == hp)
                    begin
                        state_next = P_TAP_END;
                    end
                    else
                    begin
                        dy_next = dy_reg + 1'b1;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            P_EMIT_RD:
            begin
                state_next = P_EMIT_LD;
            end
            P_EMIT_LD:
            begin
                ov_next = 1'b1;
                if (cnt_reg == '0)
                begin
                    ox_next = '0;
                    oy_next = '0;
                    of_next = 1'b0;
                    od_next = 1'b0;
                    ol_next = 1'b1;
                end
                else
                begin
                    ox_next = 8'(list_rd_reg[XW-1:0]);
                    oy_next = 8'(list_rd_reg[XW+YW-1:XW]);
                    of_next = 1'b1;
                    od_next = drop_reg;
                    ol_next = (k_reg + 1'b1 == cnt_reg);
                end
                state_next = P_EMIT_OUT;
            end
            P_EMIT_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if (ol_reg)
                    begin
                        state_next = P_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = P_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            px_reg    <= '0;
            py_reg    <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            tapv_reg  <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            drop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            ol_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            tapv_reg  <= tapv_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            drop_reg  <= drop_next;
            ov_reg    <= ov_next;
            ol_reg    <= ol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg  <= v_next;
        mx_reg <= mx_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        of_reg <= of_next;
        od_reg <= od_next;
    end

    assign peak_busy     = (state_reg != P_IDLE);
    assign out_valid     = ov_reg;
    assign stem_x        = ox_reg;
    assign stem_y        = oy_reg;
    assign peak_found    = of_reg;
    assign peaks_dropped = od_reg;
    assign last_result   = ol_reg;

endmodule

`default_nettype wire

@@ src/keypoint_vote_peak_finder.sv @@
// Pixel item: accepted, then vote read, then vote write; the next item is taken after the write.
// End-of-frame item: box sum over the frame, then peak scan over the frame with a window
// test per candidate, then one result at a time, each held while the output stalls.
// Reset and each frame end start a clearing sweep over all MAX_WIDTH*MAX_HEIGHT words of
// the vote memory; no item is accepted during it (config writes are always taken).
`timescale 1ns / 1ps
`default_nettype none

module keypoint_vote_peak_finder #(
    parameter int MAX_WIDTH       = kvp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = kvp_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_PEAKS       = kvp_pkg::MAX_PEAKS_DEF,
    parameter int MAX_VOTE_WINDOW = kvp_pkg::MAX_VOTE_WINDOW_DEF,
    parameter int MAX_PEAK_WINDOW = kvp_pkg::MAX_PEAK_WINDOW_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_write,
    input  wire [2:0]           cfg_index,
    input  wire [31:0]          cfg_data,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire [15:0]          confidence,
    input  wire signed [15:0]   shift_x,
    input  wire signed [15:0]   shift_y,
    input  wire                 end_of_frame,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [7:0]          stem_x,
    output logic [7:0]          stem_y,
    output logic                peak_found,
    output logic                peaks_dropped,
    output logic                last_result
);
    import kvp_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    // Configuration registers
    logic [8:0]  frame_width_reg, frame_height_reg;
    logic [11:0] radius_reg;
    logic [15:0] vote_thr_reg;
    logic [31:0] peak_thr_reg;
    logic [2:0]  vote_win_reg;
    logic [3:0]  peak_win_reg;

    kvp_geom_t     geom;
    logic          filt_we, scan_start, peak_busy, accum_busy;
    logic [AW-1:0] filt_addr;
    logic [31:0]   filt_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 9'd256;
            frame_height_reg <= 9'd256;
            radius_reg       <= 12'd240;
            vote_thr_reg     <= 16'd0;
            peak_thr_reg     <= 32'd4632465;
            vote_win_reg     <= 3'd3;
            peak_win_reg     <= 4'd7;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg  <= cfg_data[8:0];
                REG_FRAME_HEIGHT:   frame_height_reg <= cfg_data[8:0];
                REG_VOTE_SCALE:     radius_reg       <= cfg_data[11:0];
                REG_VOTE_THRESHOLD: vote_thr_reg     <= cfg_data[15:0];
                REG_PEAK_THRESHOLD: peak_thr_reg     <= cfg_data;
                REG_VOTE_WINDOW:    vote_win_reg     <= cfg_data[2:0];
                REG_PEAK_WINDOW:    peak_win_reg     <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp frame size to 1..MAX and the window half-sizes to the maximum window.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            geom.width = DIM_W'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            geom.width = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            geom.width = DIM_W'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            geom.height = DIM_W'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            geom.height = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            geom.height = DIM_W'(frame_height_reg);
        end
        geom.half_vote = (32'(vote_win_reg >> 1) > 32'(MAX_VOTE_WINDOW / 2))
                       ? 4'(MAX_VOTE_WINDOW / 2) : 4'(vote_win_reg >> 1);
        geom.half_peak = (32'(peak_win_reg >> 1) > 32'(MAX_PEAK_WINDOW / 2))
                       ? 5'(MAX_PEAK_WINDOW / 2) : 5'(peak_win_reg >> 1);
    end

    // Voting, box sum and clearing of the vote map
    kvp_vote_accum #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .MAX_VOTE_WINDOW (MAX_VOTE_WINDOW)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .confidence      (confidence),
        .shift_x         (shift_x),
        .shift_y         (shift_y),
        .end_of_frame    (end_of_frame),
        .geom            (geom),
        .vote_scale      (radius_reg),
        .vote_threshold  (vote_thr_reg),
        .peak_busy       (peak_busy),
        .filt_we         (filt_we),
        .filt_addr       (filt_addr),
        .filt_data       (filt_data),
        .scan_start      (scan_start),
        .accum_busy      (accum_busy)
    );

    // Local-maximum scan and result emission
    kvp_peak_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PEAKS  (MAX_PEAKS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .geom           (geom),
        .peak_threshold (peak_thr_reg),
        .filt_we        (filt_we),
        .filt_addr      (filt_addr),
        .filt_data      (filt_data),
        .scan_start     (scan_start),
        .peak_busy      (peak_busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .stem_x         (stem_x),
        .stem_y         (stem_y),
        .peak_found     (peak_found),
        .peaks_dropped  (peaks_dropped),
        .last_result    (last_result)
    );

    // An item is only taken while no result of the previous frame is pending.
    a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !out_valid)
        else $error("item accepted while a result is pending");

    // The empty-frame terminator is always the final, undropped result.
    a_terminator_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !peak_found) |-> (last_result && !peaks_dropped))
        else $error("malformed empty-frame result");

    // Nothing follows the final result of a frame.
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_result && !out_stall) |=> !out_valid)
        else $error("result after final result");

    // Busy accumulator always holds off the input.
    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accum_busy |-> in_stall)
        else $error("input open while accumulator busy");

endmodule

`default_nettype wire

@@ verif/tb_keypoint_vote_peak_finder.sv @@
// Self-checking testbench for keypoint_vote_peak_finder: Hough voting plus peak search.
// Depends on kvp_pkg (register indexes) and the keypoint_vote_peak_finder top level.
`timescale 1ns / 1ps

module tb_keypoint_vote_peak_finder;
    import kvp_pkg::*;

    localparam int MAP_W       = 256;
    localparam int MAP_H       = 256;
    localparam int PEAK_LIMIT  = 64;
    localparam int IDLE_LIMIT  = 300000;  // clear sweep plus the slowest frame, several times
    localparam int SETTLE_CYC  = 20;
    localparam int HOLD_CYC    = 4000;

    typedef struct {
        logic [15:0]        conf;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               eof;
        bit                 fixed;     // expected result typed in the table
    } pixel_t;

    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        logic       found;
        logic       dropped;
        logic       last;
    } stem_t;

    typedef enum {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        pixel_t      px;
        stem_t       res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = REG_FRAME_WIDTH;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] confidence = '0;
    logic signed [15:0] shift_x = '0;
    logic signed [15:0] shift_y = '0;
    logic        end_of_frame = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  stem_x;
    logic [7:0]  stem_y;
    logic        peak_found;
    logic        peaks_dropped;
    logic        last_result;

    keypoint_vote_peak_finder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .confidence   (confidence),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .stem_x       (stem_x),
        .stem_y       (stem_y),
        .peak_found   (peak_found),
        .peaks_dropped(peaks_dropped),
        .last_result  (last_result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: register shadows, vote map, pixel counters
    // ------------------------------------------------------------------
    logic [8:0]  fw_reg, fh_reg;
    logic [11:0] radius_reg;
    logic [15:0] vthr_reg;
    logic [31:0] pthr_reg;
    logic [2:0]  vwin_reg;
    logic [3:0]  pwin_reg;

    logic [31:0] vote_map [MAP_W*MAP_H];
    logic [31:0] box_map  [MAP_W*MAP_H];
    int          col_cnt, row_cnt;

    pixel_t pixel_fifo[$];
    stem_t  stem_expect_q[$];
    stem_t  fixed_q[$];        // typed results for table rows, in item order
    row_t   table_rows[$];

    int  mismatches = 0;
    int  stems_seen = 0;
    int  pixels_sent = 0;
    int  frames_done = 0;
    int  idle_cycles = 0;
    bit  want_hold = 1'b0;

    function automatic int clamp_dim(logic [8:0] v);
        if (v == 0)
            return 1;
        return (v > MAP_W) ? MAP_W : int'(v);
    endfunction

    function automatic int half_win(int v, int maxw);
        int h;
        h = v >> 1;
        return (h > (maxw >> 1)) ? (maxw >> 1) : h;
    endfunction

    // Vote coordinate: (pos + radius*shift/2^18) truncated toward zero, in [0, lim)
    function automatic bit vote_at(int pos, logic signed [15:0] sh, int lim, output int r);
        longint s;
        s = longint'(pos) * 262144 + longint'(radius_reg) * longint'(sh);
        r = 0;
        if (s <= -262144)
            return 1'b0;
        r = (s < 0) ? 0 : int'(s >>> 18);
        return r < lim;
    endfunction

    task automatic clear_votes();
        for (int i = 0; i < MAP_W*MAP_H; i++)
            vote_map[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
    endtask

    task automatic apply_cfg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_FRAME_WIDTH:    fw_reg = d[8:0];
            REG_FRAME_HEIGHT:   fh_reg = d[8:0];
            REG_VOTE_SCALE:     radius_reg = d[11:0];
            REG_VOTE_THRESHOLD: vthr_reg = d[15:0];
            REG_PEAK_THRESHOLD: pthr_reg = d;
            REG_VOTE_WINDOW:    vwin_reg = d[2:0];
            REG_PEAK_WINDOW:    pwin_reg = d[3:0];
            default: ;
        endcase
    endtask

    // Accumulate one pixel; on end of frame, box-sum, search peaks, queue the stems
    task automatic vote_and_find(pixel_t p);
        int w, h, vx, vy, hv, hp, total, nfound, xx, yy;
        longint acc;
        logic [31:0] v, mx;
        int fx[PEAK_LIMIT];
        int fy[PEAK_LIMIT];
        stem_t r;
        w = clamp_dim(fw_reg);
        h = clamp_dim(fh_reg);
        if (p.conf > vthr_reg && vote_at(col_cnt, p.sx, w, vx) && vote_at(row_cnt, p.sy, h, vy))
        begin
            acc = longint'(vote_map[vy*MAP_W + vx]) + longint'(p.conf);
            vote_map[vy*MAP_W + vx] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        end
        if (!p.eof)
        begin
            if (col_cnt + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
            end
            else
            begin
                col_cnt++;
            end
            return;
        end
        hv = half_win(vwin_reg, 7);
        hp = half_win(pwin_reg, 15);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
            begin
                acc = 0;
                for (int dy = -hv; dy <= hv; dy++)
                    for (int dx = -hv; dx <= hv; dx++)
                    begin
                        yy = y + dy;
                        xx = x + dx;
                        if (yy >= 0 && yy < h && xx >= 0 && xx < w)
                            acc += vote_map[yy*MAP_W + xx];
                    end
                box_map[y*MAP_W + x] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            end
        total = 0;
        nfound = 0;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
            begin
                v = box_map[y*MAP_W + x];
                if (v > pthr_reg)
                begin
                    mx = '0;
                    for (int dy = -hp; dy <= hp; dy++)
                        for (int dx = -hp; dx <= hp; dx++)
                        begin
                            yy = y + dy;
                            xx = x + dx;
                            if (yy >= 0 && yy < h && xx >= 0 && xx < w)
                                if (box_map[yy*MAP_W + xx] > mx)
                                    mx = box_map[yy*MAP_W + xx];
                        end
                    if (v == mx)
                    begin
                        total++;
                        if (nfound < PEAK_LIMIT)
                        begin
                            fx[nfound] = x;
                            fy[nfound] = y;
                            nfound++;
                        end
                    end
                end
            end
        clear_votes();
        frames_done++;
        if (nfound == 0)
        begin
            r = '{8'd0, 8'd0, 1'b0, 1'b0, 1'b1};
            stem_expect_q.push_back(r);
        end
        for (int k = 0; k < nfound; k++)
        begin
            r.x = fx[k][7:0];
            r.y = fy[k][7:0];
            r.found = 1'b1;
            r.dropped = (total > PEAK_LIMIT);
            r.last = (k + 1 == nfound);
            stem_expect_q.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Pixel sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        pixel_t cur;
        bit     take;
        take = in_valid && !in_stall;
        if (take)
        begin
            cur = pixel_fifo.pop_front();
            pixels_sent++;
            if (cur.fixed)
            begin
                // keep the predictor state moving, but check the typed result
                vote_and_find(cur);
                stem_expect_q.delete(stem_expect_q.size() - 1);
                stem_expect_q.push_back(fixed_q.pop_front());
            end
            else
            begin
                vote_and_find(cur);
            end
        end
        if (in_valid && !take)
        begin
            // hold the offered item
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (pixel_fifo.size() > 0)
        begin
            in_valid     <= 1'b1;
            confidence   <= pixel_fifo[0].conf;
            shift_x      <= pixel_fifo[0].sx;
            shift_y      <= pixel_fifo[0].sy;
            end_of_frame <= pixel_fifo[0].eof;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall pattern steps through four modes; long hold on request
    // ------------------------------------------------------------------
    int hold_left = 0;
    int stall_phase = 0;

    always @(posedge clk)
    begin
        int mode;
        stall_phase++;
        mode = (stall_phase / 64) % 4;
        if (want_hold)
        begin
            want_hold = 1'b0;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 6);
                default: out_stall <= (stall_phase % 3 == 0);
            endcase
        end
    end

    // Compare every accepted stem with the oldest expectation
    always @(posedge clk)
    begin
        stem_t e;
        if (out_valid && !out_stall)
        begin
            stems_seen++;
            if (stem_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%0d y=%0d found=%0b dropped=%0b last=%0b",
                             stem_x, stem_y, peak_found, peaks_dropped, last_result);
            end
            else
            begin
                e = stem_expect_q.pop_front();
                if (stem_x !== e.x || stem_y !== e.y || peak_found !== e.found ||
                    peaks_dropped !== e.dropped || last_result !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d f=%0b d=%0b l=%0b, ",
                                 e.x, e.y, e.found, e.dropped, e.last,
                                 "got x=%0d y=%0d f=%0b d=%0b l=%0b",
                                 stem_x, stem_y, peak_found, peaks_dropped, last_result);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no accepted item either way
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("tb_keypoint_vote_peak_finder NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic settle();
        while (pixel_fifo.size() > 0 || stem_expect_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        apply_cfg(idx, d);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic pixel_t mk_pix(logic [15:0] c, logic [15:0] x, logic [15:0] y, logic e);
        pixel_t p;
        p.conf = c;
        p.sx = x;
        p.sy = y;
        p.eof = e;
        p.fixed = 1'b0;
        return p;
    endfunction

    function automatic logic [15:0] rand_shift();
        // mostly within half the shift range, sometimes the full range
        if ($urandom_range(0, 9) < 7)
            return 16'($urandom_range(0, 32768) - 16384);
        return 16'($urandom);
    endfunction

    task automatic t_cfg(logic [2:0] idx, logic [31:0] d);
        row_t r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = d;
        table_rows.push_back(r);
    endtask

    task automatic t_pix(logic [15:0] c, logic [15:0] x, logic [15:0] y, logic e);
        row_t r;
        r.kind = ROW_PIX;
        r.px = mk_pix(c, x, y, e);
        table_rows.push_back(r);
    endtask

    // pixel whose frame yields only the empty-frame terminator
    task automatic t_pix_empty(logic [15:0] c);
        row_t r;
        r.kind = ROW_PIX;
        r.px = mk_pix(c, 16'h0000, 16'h0000, 1'b1);
        r.px.fixed = 1'b1;
        r.res = '{8'd0, 8'd0, 1'b0, 1'b0, 1'b1};
        table_rows.push_back(r);
    endtask

    task automatic random_frame(int npix, bit split);
        int w;
        for (int i = 0; i < npix; i++)
        begin
            // shrink the frame halfway through, with the block idle
            if (split && i == npix / 2)
            begin
                settle();
                w = clamp_dim(fw_reg);
                write_reg(REG_FRAME_WIDTH, (w > 1) ? w - 1 : 1);
            end
            pixel_fifo.push_back(mk_pix(16'($urandom), rand_shift(), rand_shift(),
                                        i == npix - 1));
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int w, h, npix;
        fw_reg = 9'd256;
        fh_reg = 9'd256;
        radius_reg = 12'd240;
        vthr_reg = '0;
        pthr_reg = 32'd4632465;
        vwin_reg = 3'd3;
        pwin_reg = 4'd7;
        clear_votes();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Width 0 acts as 1; a zero confidence never votes, so only the terminator comes
        t_cfg(REG_FRAME_WIDTH, 32'd0);
        t_cfg(REG_FRAME_HEIGHT, 32'd1);
        t_pix_empty(16'h0000);
        // Zero radius, every voting pixel a peak of its own; shift extremes have no effect
        t_cfg(REG_FRAME_WIDTH, 32'd3);
        t_cfg(REG_FRAME_HEIGHT, 32'd2);
        t_cfg(REG_VOTE_SCALE, 32'd0);
        t_cfg(REG_PEAK_THRESHOLD, 32'd0);
        t_cfg(REG_VOTE_WINDOW, 32'd1);
        t_cfg(REG_PEAK_WINDOW, 32'd1);
        t_pix(16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
        t_pix(16'h0001, 16'h0000, 16'h0000, 1'b0);
        t_pix(16'h0000, 16'h1234, 16'hEDCB, 1'b0);
        t_pix(16'h8000, 16'hFFFF, 16'h0001, 1'b0);
        t_pix(16'hFFFF, 16'h7FFF, 16'h8000, 1'b0);
        t_pix(16'h0002, 16'h0000, 16'h0000, 1'b1);
        // Largest radius: small negative offsets truncate to zero, big ones drop the vote;
        // window 0 acts as 1
        t_cfg(REG_FRAME_WIDTH, 32'd8);
        t_cfg(REG_FRAME_HEIGHT, 32'd1);
        t_cfg(REG_VOTE_SCALE, 32'd4095);
        t_cfg(REG_VOTE_WINDOW, 32'd0);
        t_cfg(REG_PEAK_WINDOW, 32'd0);
        t_pix(16'h4000, 16'hFFFF, 16'h0000, 1'b0);
        t_pix(16'h5000, 16'h7FFF, 16'h0000, 1'b0);
        t_pix(16'h6000, 16'h0040, 16'hFFF0, 1'b0);
        t_pix(16'h7000, 16'hF000, 16'h0000, 1'b1);
        // Width above the maximum acts as 256; largest windows; top threshold blocks all
        t_cfg(REG_FRAME_WIDTH, 32'h1FF);
        t_cfg(REG_VOTE_WINDOW, 32'd7);
        t_cfg(REG_PEAK_WINDOW, 32'd15);
        t_cfg(REG_PEAK_THRESHOLD, 32'hFFFF_FFFF);
        t_pix(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        t_pix(16'hFFFF, 16'h0100, 16'h0000, 1'b0);
        t_pix_empty(16'hFFFF);
        // Tallest frame; top vote threshold means no pixel can vote
        t_cfg(REG_FRAME_WIDTH, 32'd1);
        t_cfg(REG_FRAME_HEIGHT, 32'h1FF);
        t_cfg(REG_VOTE_THRESHOLD, 32'hFFFF);
        t_cfg(REG_PEAK_THRESHOLD, 32'd0);
        t_pix(16'hFFFF, 16'h0000, 16'h4000, 1'b0);
        t_pix_empty(16'hFFFF);
        // More pixels than a 2x2 frame holds: counters wrap and vote again
        t_cfg(REG_FRAME_WIDTH, 32'd2);
        t_cfg(REG_FRAME_HEIGHT, 32'd2);
        t_cfg(REG_VOTE_THRESHOLD, 32'd0);
        t_cfg(REG_VOTE_SCALE, 32'd16);
        t_cfg(REG_VOTE_WINDOW, 32'd2);
        t_cfg(REG_PEAK_WINDOW, 32'd3);
        for (int i = 0; i < 6; i++)
            t_pix(16'(1000 * (i + 1)), 16'(i * 5000 - 12000), 16'(9000 - i * 4000), i == 5);

        foreach (table_rows[i])
        begin
            if (table_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(table_rows[i].idx, table_rows[i].data);
            end
            else
            begin
                if (table_rows[i].px.fixed)
                    fixed_q.push_back(table_rows[i].res);
                pixel_fifo.push_back(table_rows[i].px);
            end
        end
        settle();

        // Overflow under pressure: hold off the receiver while a 256-wide line of
        // 70 voting pixels and a short second frame keep coming
        write_reg(REG_FRAME_WIDTH, 32'd256);
        write_reg(REG_FRAME_HEIGHT, 32'd1);
        write_reg(REG_VOTE_SCALE, 32'd0);
        write_reg(REG_VOTE_WINDOW, 32'd1);
        write_reg(REG_PEAK_WINDOW, 32'd1);
        want_hold = 1'b1;
        for (int i = 0; i < 70; i++)
            pixel_fifo.push_back(mk_pix(16'($urandom_range(1, 65535)), 16'($urandom),
                                        16'($urandom), i == 69));
        for (int i = 0; i < 10; i++)
            pixel_fifo.push_back(mk_pix(16'($urandom), 16'($urandom), 16'($urandom), i == 9));
        settle();

        // Random frames: small sizes, well-formed mostly, one overrun and one mid-frame shrink
        for (int f = 0; f < 6; f++)
        begin
            w = $urandom_range(2, 8);
            h = $urandom_range(1, 5);
            write_reg(REG_FRAME_WIDTH, w);
            write_reg(REG_FRAME_HEIGHT, h);
            write_reg(REG_VOTE_SCALE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                                 : $urandom_range(0, 48));
            write_reg(REG_VOTE_THRESHOLD, $urandom_range(0, 30000));
            write_reg(REG_PEAK_THRESHOLD, ($urandom_range(0, 3) == 0) ? $urandom
                                                                     : $urandom_range(0, 150000));
            write_reg(REG_VOTE_WINDOW, $urandom_range(0, 7));
            write_reg(REG_PEAK_WINDOW, $urandom_range(0, 15));
            npix = w * h;
            if (f == 1)
                npix += $urandom_range(2, 6);
            else if (f == 4)
                npix = $urandom_range(1, npix);
            if (npix > 24)
                npix = 24;
            random_frame(npix, f == 3);
        end

        repeat (200) @(posedge clk);
        $display("covered %0d pixels over %0d frames, %0d results checked, %0d mismatches",
                 pixels_sent, frames_done, stems_seen, mismatches);
        if (mismatches == 0 && stem_expect_q.size() == 0)
            $display("tb_keypoint_vote_peak_finder OK");
        else
            $display("tb_keypoint_vote_peak_finder NOT OK");
        $finish;
    end

endmodule
